[src/plucked_string_synth_unit_macros.svh]
// Assertion macros for the plucked string synth unit.
`ifndef PLUCKED_STRING_SYNTH_UNIT_MACROS_SVH
`define PLUCKED_STRING_SYNTH_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pss assertion failed");

// next-cycle implication, disabled during reset
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pss assertion failed");

`endif

[src/pss_pkg.sv]
// Package: constants, register codes and LFSR helpers of the plucked string synth unit.
`default_nettype none

package pss_pkg;

    localparam int DELAY_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int DELAY_BITS     = 10;
    localparam int ATTEN_BITS     = 16;
    localparam int LFSR_BITS      = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELAY_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTENUATION  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NOISE_SEED   = 2'd2;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_PLUCK = 1'b1;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET = 10'd100;
    localparam logic [ATTEN_BITS-1:0] ATTEN_RESET = 16'd64881;
    localparam logic [LFSR_BITS-1:0]  SEED_RESET  = 16'd44257;
    localparam logic [LFSR_BITS-1:0]  LFSR_TAPS   = 16'hB400;

    // Galois step, x^16+x^14+x^13+x^11+1
    function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] s);
        logic [LFSR_BITS-1:0] n;
        n = s >> 1;
        if (s[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

    // zero seed would lock the LFSR
    function automatic logic [LFSR_BITS-1:0] seed_load(input logic [LFSR_BITS-1:0] s);
        return (s == '0) ? LFSR_BITS'(1) : s;
    endfunction

endpackage

`default_nettype wire

[src/pss_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none

module pss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/plucked_string_synth_unit.sv]
// Top level: Karplus-Strong plucked string voice over a circular delay RAM.
//
// Requests enter on in_valid/in_ready. req_type 0 is a tick: it yields one
// sample on out_valid/out_ready with block_last copying frame_last.
// req_type 1 is a pluck: the delay RAM is refilled with LFSR noise and no
// sample is produced.
// A tick runs two reads and one write of the single-port delay RAM, then
// goes back to idle; in_ready is low meanwhile. A pluck writes every word
// of the delay RAM, one RAM write per cycle.
// Results sit in an output register; a new tick runs while an earlier sample
// waits, and only its final write cycle holds while that sample is not taken.
// Registers are written on cfg_valid/cfg_ready (cfg_index, cfg_data); the
// user must write them only while no request is in flight, which the block
// itself does not enforce. Writing delay_length to DELAY_DEPTH or more
// subtracts DELAY_DEPTH repeatedly, with both ready signals low. After reset
// a clearing pass zeroes the RAM; in_ready stays low, register writes are taken.
`default_nettype none

`include "plucked_string_synth_unit_macros.svh"

module plucked_string_synth_unit #(
    parameter int DELAY_DEPTH = pss_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = pss_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [pss_pkg::CFG_DATA_BITS-1:0]  cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               req_type,
    input  wire logic                               frame_last,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [SAMPLE_BITS-1:0]           sample_out,
    output logic                                    block_last
);

    import pss_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int WW = ((AW > DELAY_BITS) ? AW : DELAY_BITS) + 1;
    localparam logic [WW-1:0] DEPTH_W   = WW'(DELAY_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_B,
        ST_AVG,
        ST_WRITE,
        ST_FILL
    } state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            cnt_reg, cnt_next;
    logic [AW-1:0]            wi_reg, wi_next;
    logic [AW-1:0]            rd_reg, rd_next;
    logic [DELAY_BITS-1:0]    delay_reg, delay_next;
    logic [ATTEN_BITS-1:0]    atten_reg, atten_next;
    logic [LFSR_BITS-1:0]     lfsr_reg, lfsr_next;
    logic signed [SAMPLE_BITS-1:0] a_reg, a_next;
    logic signed [SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic                     frame_reg, frame_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                     last_reg, last_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_addr;
    logic [SAMPLE_BITS-1:0]   ram_wdata;
    logic [SAMPLE_BITS-1:0]   ram_rdata;

    logic                     reducing;
    logic [WW-1:0]            delay_sub;
    logic [WW-1:0]            back_diff;
    logic [WW-1:0]            back_wrap;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            rp_addr;
    logic [LFSR_BITS-1:0]     lfsr_stepped;
    logic [LFSR_BITS+SAMPLE_BITS-1:0] noise_wide;
    logic [SAMPLE_BITS:0]     pair_sum;
    logic signed [SAMPLE_BITS+16:0] product;
    logic [SAMPLE_BITS-1:0]   feedback;
    logic                     out_free;
    logic                     in_fire;
    logic                     cfg_fire;

    pss_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(DELAY_DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // delay reduced modulo depth by repeated subtraction
    assign reducing  = (WW'(delay_reg) >= DEPTH_W);
    assign delay_sub = WW'(delay_reg) - DEPTH_W;

    // tap addresses, wrapping at zero
    assign back_diff = WW'(wi_reg) - WW'(delay_reg);
    assign back_wrap = back_diff + DEPTH_W;
    assign rd_addr   = back_diff[WW-1] ? back_wrap[AW-1:0] : back_diff[AW-1:0];
    assign rp_addr   = (rd_reg == '0) ? LAST_ADDR : (rd_reg - AW'(1));

    assign lfsr_stepped = lfsr_step(lfsr_reg);
    assign noise_wide   = {lfsr_stepped, {SAMPLE_BITS{1'b0}}};

    assign pair_sum = {a_reg[SAMPLE_BITS-1], a_reg} +
                      {ram_rdata[SAMPLE_BITS-1], ram_rdata};
    assign product  = avg_reg * $signed({1'b0, atten_reg});
    assign feedback = product[SAMPLE_BITS+15:16];

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && !reducing;
    assign cfg_ready = !reducing;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wi_next        = wi_reg;
        rd_next        = rd_reg;
        delay_next     = delay_reg;
        atten_next     = atten_reg;
        lfsr_next      = lfsr_reg;
        a_next         = a_reg;
        avg_next       = avg_reg;
        frame_next     = frame_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sample_next    = sample_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_addr       = rp_addr;
        ram_wdata      = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = cnt_reg;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_addr = rd_addr;
                if (in_fire)
                begin
                    if (req_type == REQ_PLUCK)
                    begin
                        cnt_next   = '0;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        rd_next    = rd_addr;
                        frame_next = frame_last;
                        state_next = ST_RD_B;
                    end
                end
            end
            ST_RD_B:
            begin
                ram_addr   = rp_addr;
                a_next     = ram_rdata;
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                avg_next   = pair_sum[SAMPLE_BITS:1];
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                ram_addr  = wi_reg;
                ram_wdata = feedback;
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    out_valid_next = 1'b1;
                    sample_next    = avg_reg;
                    last_next      = frame_reg;
                    wi_next        = (wi_reg == LAST_ADDR) ? '0 : (wi_reg + AW'(1));
                    state_next     = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_addr  = cnt_reg;
                ram_wdata = noise_wide[LFSR_BITS+SAMPLE_BITS-1 -: SAMPLE_BITS];
                lfsr_next = lfsr_stepped;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_fire)
        begin
            case (cfg_index)
                CFG_DELAY_LENGTH: delay_next = cfg_data[DELAY_BITS-1:0];
                CFG_ATTENUATION:  atten_next = cfg_data[ATTEN_BITS-1:0];
                CFG_NOISE_SEED:   lfsr_next  = seed_load(cfg_data[LFSR_BITS-1:0]);
                default:          ;
            endcase
        end
        else if (reducing)
        begin
            delay_next = delay_sub[DELAY_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            wi_reg        <= '0;
            rd_reg        <= '0;
            delay_reg     <= DELAY_RESET;
            atten_reg     <= ATTEN_RESET;
            lfsr_reg      <= SEED_RESET;
            a_reg         <= '0;
            avg_reg       <= '0;
            frame_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wi_reg        <= wi_next;
            rd_reg        <= rd_next;
            delay_reg     <= delay_next;
            atten_reg     <= atten_next;
            lfsr_reg      <= lfsr_next;
            a_reg         <= a_next;
            avg_reg       <= avg_next;
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
            sample_reg    <= sample_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;
    assign block_last = last_reg;

    `PSS_ASSERT_NOW(a_no_req_while_busy, clk, rst_n, (state_reg != ST_IDLE) || reducing, !in_ready)
    `PSS_ASSERT_NEXT(a_tick_reads_pair, clk, rst_n, in_fire && (req_type == REQ_TICK), state_reg == ST_RD_B)
    `PSS_ASSERT_NOW(a_ram_write_states, clk, rst_n, ram_we, (state_reg == ST_CLEAR) || (state_reg == ST_FILL) || (state_reg == ST_WRITE))
    `PSS_ASSERT_NEXT(a_index_moves_on_write, clk, rst_n, !ram_we || (state_reg != ST_WRITE), $stable(wi_reg))

endmodule

`default_nettype wire
